// ----- design/ibs_pkg.sv -----
// Shared types, constants and helpers for the I2C bus snoop capture block.
// No dependencies; imported by every module of the block but the generic RAM.
package ibs_pkg;

   localparam int IBS_DEPTH = 256;                 // capture store depth, 2..256
   localparam int IBS_AW    = (IBS_DEPTH > 1) ? $clog2(IBS_DEPTH) : 1;

   // event codes on req_action
   localparam logic [1:0] ACT_SCL_RISE   = 2'd0;
   localparam logic [1:0] ACT_SDA_CHANGE = 2'd1;
   localparam logic [1:0] ACT_READ       = 2'd2;

   localparam logic [3:0] BIT_RW  = 4'd7;          // R/W bit position in the address byte
   localparam logic [3:0] BIT_ACK = 4'd8;          // acknowledge bit position
   localparam logic [1:0] BYTE_ADDR = 2'd0;
   localparam logic [1:0] BYTE_PTR  = 2'd1;
   localparam logic [1:0] BYTE_DATA = 2'd2;        // saturating value

   typedef struct packed {
      logic              idle;
      logic [3:0]        bit_pos;
      logic [1:0]        byte_pos;
      logic [7:0]        shift;
      logic [IBS_AW-1:0] ptr;
      logic [6:0]        addr;
      logic              wr_dir;
   } ibs_state_type;

   typedef struct packed {
      logic              valid;
      logic [IBS_AW-1:0] index;
      logic [7:0]        value;
   } ibs_store_type;

   localparam ibs_state_type IBS_STATE_RESET = '{
      idle:     1'b1,
      bit_pos:  4'd0,
      byte_pos: BYTE_ADDR,
      shift:    8'd0,
      ptr:      '0,
      addr:     7'd0,
      wr_dir:   1'b1
   };

   // byte modulo store depth: restoring reduction, one conditional subtract per bit
   function automatic logic [IBS_AW-1:0] ibs_mod(input logic [7:0] v);
      logic [8:0] r;
      r = {1'b0, v};
      for (int k = 7; k >= 0; k--) begin
         if ((IBS_DEPTH << k) <= 255) begin
            if (int'(r) >= (IBS_DEPTH << k)) begin
               r = r - 9'(IBS_DEPTH << k);
            end
         end
      end
      return r[IBS_AW-1:0];
   endfunction

endpackage

// ----- design/ibs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ibs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- design/ibs_decode.sv -----
// Bus event decoder: START/STOP detection, bit shifting, address/pointer/data handling.
// Depends on ibs_pkg.
module ibs_decode
   import ibs_pkg::*;
(
   input  ibs_state_type st,
   input  logic [1:0]    action,
   input  logic          sda,
   input  logic          scl,
   output ibs_state_type st_nx,
   output ibs_store_type store
);

   always_comb begin
      st_nx = st;
      store = '0;
      unique case (action)
         ACT_SCL_RISE: begin
            if (!st.idle) begin
               priority if (st.bit_pos == BIT_RW && st.byte_pos == BYTE_ADDR) begin
                  st_nx.wr_dir  = !sda;
                  st_nx.bit_pos = st.bit_pos + 4'd1;
               end else if (st.bit_pos >= BIT_ACK) begin
                  priority if (st.byte_pos == BYTE_ADDR) begin
                     if (!sda) begin
                        st_nx.addr = st.shift[6:0];
                     end
                  end else if (st.byte_pos == BYTE_PTR && st.wr_dir && !sda) begin
                     st_nx.ptr = ibs_mod(st.shift);
                  end else begin
                     store.valid = 1'b1;
                     store.index = st.ptr;
                     store.value = st.shift;
                     st_nx.ptr   = (st.ptr == IBS_AW'(IBS_DEPTH - 1)) ? '0
                                                                       : st.ptr + 1'b1;
                  end
                  if (st.byte_pos != BYTE_DATA) begin
                     st_nx.byte_pos = st.byte_pos + 2'd1;
                  end
                  st_nx.shift   = 8'd0;
                  st_nx.bit_pos = 4'd0;
               end else begin
                  st_nx.shift   = {st.shift[6:0], sda};
                  st_nx.bit_pos = st.bit_pos + 4'd1;
               end
            end
         end
         ACT_SDA_CHANGE: begin
            if (scl) begin
               if (sda) begin
                  st_nx.idle = 1'b1;                 // STOP
               end else if (st.idle) begin
                  st_nx.bit_pos  = 4'd0;             // START; repeated START ignored
                  st_nx.byte_pos = BYTE_ADDR;
                  st_nx.shift    = 8'd0;
                  st_nx.ptr      = '0;
                  st_nx.idle     = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- design/i2c_bus_snoop_register_capture.sv -----
// An item passes the input register, then the result register, which drives the result.
// Throughput: one item per cycle while the result channel does not stall; the capture
// RAM has one write and one read port.
// Reset (synchronous, active high): bus idle, counters and address cleared, direction
// write; the capture store reads as zero via per-entry valid bits cleared at once.
// Depends on ibs_pkg, ibs_decode, ibs_ram.
module i2c_bus_snoop_register_capture
   import ibs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_action,
   input  logic       req_sda_level,
   input  logic       req_scl_level,
   input  logic [7:0] req_read_index,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_stored_valid,
   output logic [7:0] rsp_stored_index,
   output logic [7:0] rsp_stored_value,
   output logic [6:0] rsp_target_addr,
   output logic       rsp_bus_idle,
   output logic       rsp_master_writing,
   output logic [7:0] rsp_read_value
);

   // --- stage 1: input register ---
   logic       s1_valid_ff, s1_valid_in;
   logic [1:0] s1_action_ff;
   logic       s1_sda_ff, s1_scl_ff;
   logic [7:0] s1_index_ff;

   // --- stage 2: result register ---
   logic        s2_valid_ff, s2_valid_in;
   logic        s2_is_read_ff, s2_hit_ff;
   ibs_store_type s2_store_ff;
   logic [6:0]  s2_addr_ff;
   logic        s2_idle_ff, s2_wr_ff;

   // bus monitor state and per-entry written flags of the capture store
   ibs_state_type          st_ff, st_in;
   ibs_store_type          store;
   logic [IBS_DEPTH-1:0]   written_ff, written_in;
   logic [IBS_AW-1:0]      rd_addr;
   logic [7:0]             ram_q;

   logic accept, s1_move, s2_free;

   // result register frees when empty or when its item is taken this cycle
   assign s2_free   = !s2_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && s2_free;
   assign req_stall = s1_valid_ff && !s2_free;
   assign accept    = req_valid && !req_stall;

   assign s1_valid_in = accept || (s1_valid_ff && !s1_move);
   assign s2_valid_in = s1_move || (s2_valid_ff && rsp_stall);

   assign rd_addr = ibs_mod(s1_index_ff);

   ibs_decode u_decode (
      .st     (st_ff),
      .action (s1_action_ff),
      .sda    (s1_sda_ff),
      .scl    (s1_scl_ff),
      .st_nx  (st_in),
      .store  (store)
   );

   // store write and read share the stage-1 edge; a read item never writes,
   // so a read always sees every earlier item's write
   ibs_ram #(
      .WIDTH (8),
      .DEPTH (IBS_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (s1_move && store.valid),
      .wr_addr (store.index),
      .wr_data (store.value),
      .rd_en   (s1_move),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   always_comb begin
      written_in = written_ff;
      if (s1_move && store.valid) begin
         written_in[store.index] = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         st_ff       <= IBS_STATE_RESET;
         written_ff  <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         written_ff  <= written_in;
         if (s1_move) begin
            st_ff <= st_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_action_ff <= req_action;
         s1_sda_ff    <= req_sda_level;
         s1_scl_ff    <= req_scl_level;
         s1_index_ff  <= req_read_index;
      end
      if (s1_move) begin
         s2_is_read_ff <= (s1_action_ff == ACT_READ);
         s2_hit_ff     <= written_ff[rd_addr];
         s2_store_ff   <= store;
         s2_addr_ff    <= st_in.addr;
         s2_idle_ff    <= st_in.idle;
         s2_wr_ff      <= st_in.wr_dir;
      end
   end

   assign rsp_valid          = s2_valid_ff;
   assign rsp_stored_valid   = s2_store_ff.valid;
   assign rsp_stored_index   = 8'(s2_store_ff.index);
   assign rsp_stored_value   = s2_store_ff.value;
   assign rsp_target_addr    = s2_addr_ff;
   assign rsp_bus_idle       = s2_idle_ff;
   assign rsp_master_writing = s2_wr_ff;
   // unwritten entries read as zero; RAM output holds while the result stalls
   assign rsp_read_value     = (s2_is_read_ff && s2_hit_ff) ? ram_q : 8'd0;

   // a byte is only ever stored during a transfer
   a_store_busy : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stored_valid) |-> !rsp_bus_idle)
      else $error("byte stored while bus idle");

   // non-read items return zero read data
   a_read_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !s2_is_read_ff) |-> (rsp_read_value == 8'd0))
      else $error("read data on non-read item");

   // bit counter never passes the acknowledge bit
   a_bit_range : assert property (@(posedge clock) disable iff (reset)
      st_ff.bit_pos <= BIT_ACK)
      else $error("bit position out of range");

   // byte counter saturates at the data position
   a_byte_range : assert property (@(posedge clock) disable iff (reset)
      st_ff.byte_pos != 2'd3)
      else $error("byte position out of range");

   // state only changes when an item moves through
   a_state_hold : assert property (@(posedge clock) disable iff (reset)
      !$past(s1_move) && !$past(reset) |-> $stable(st_ff))
      else $error("bus state changed without an item");

endmodule

// ----- tb/ibs_snoop_checker.sv -----
`timescale 1ns / 100ps
// Checker for the I2C bus snoop capture block. It watches both channels, predicts every
// result from its own copy of the monitor state and compares each field. Depends on ibs_pkg.
module ibs_snoop_checker
   import ibs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [1:0] req_action,
   input  logic       req_sda_level,
   input  logic       req_scl_level,
   input  logic [7:0] req_read_index,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic       rsp_stored_valid,
   input  logic [7:0] rsp_stored_index,
   input  logic [7:0] rsp_stored_value,
   input  logic [6:0] rsp_target_addr,
   input  logic       rsp_bus_idle,
   input  logic       rsp_master_writing,
   input  logic [7:0] rsp_read_value,
   output int         mismatches,
   output int         awaiting
);

   typedef struct packed {
      logic       st_valid;
      logic [7:0] st_index;
      logic [7:0] st_value;
      logic [6:0] address;
      logic       idle;
      logic       writing;
      logic [7:0] rd_value;
   } snoop_result_type;

   snoop_result_type pending_results[$];

   // predicted monitor state
   logic [7:0] capture_mem [IBS_DEPTH];
   logic [6:0] tgt_addr;
   int         wr_ptr;
   logic       bus_free;
   logic [3:0] bit_cnt;
   logic [1:0] byte_cnt;
   logic [7:0] shreg;
   logic       dir_write;
   int         mismatch_count = 0;

   task automatic clear_monitor();
      foreach (capture_mem[i]) capture_mem[i] = 8'd0;
      tgt_addr  = 7'd0;
      wr_ptr    = 0;
      bus_free  = 1'b1;
      bit_cnt   = 4'd0;
      byte_cnt  = BYTE_ADDR;
      shreg     = 8'd0;
      dir_write = 1'b1;
      pending_results.delete();
   endtask

   function automatic snoop_result_type predict_bus_event(input logic [1:0] act,
                                                          input logic sda, input logic scl,
                                                          input logic [7:0] ridx);
      snoop_result_type r;
      int               p;
      r = '0;
      case (act)
         ACT_SCL_RISE: if (!bus_free) begin
            if (bit_cnt == BIT_RW && byte_cnt == BYTE_ADDR) begin
               dir_write = !sda;
               bit_cnt++;
            end else if (bit_cnt >= BIT_ACK) begin
               if (byte_cnt == BYTE_ADDR) begin
                  if (!sda) tgt_addr = shreg[6:0];
               end else if (byte_cnt == BYTE_PTR && dir_write && !sda) begin
                  wr_ptr = int'(shreg) % IBS_DEPTH;
               end else begin
                  // data byte, or a NACKed pointer byte: stored with ACK or NACK
                  p = wr_ptr % IBS_DEPTH;
                  capture_mem[p] = shreg;
                  r.st_valid = 1'b1;
                  r.st_index = 8'(p);
                  r.st_value = shreg;
                  wr_ptr = (p + 1) % IBS_DEPTH;
               end
               if (byte_cnt != BYTE_DATA) byte_cnt++;
               shreg   = 8'd0;
               bit_cnt = 4'd0;
            end else begin
               shreg = {shreg[6:0], sda};
               bit_cnt++;
            end
         end
         ACT_SDA_CHANGE: if (scl) begin
            if (sda) begin
               bus_free = 1'b1;
            end else if (bus_free) begin
               bit_cnt  = 4'd0;
               byte_cnt = BYTE_ADDR;
               shreg    = 8'd0;
               wr_ptr   = 0;
               bus_free = 1'b0;
            end
         end
         ACT_READ: r.rd_value = capture_mem[int'(ridx) % IBS_DEPTH];
         default: ;
      endcase
      r.address = tgt_addr;
      r.idle    = bus_free;
      r.writing = dir_write;
      return r;
   endfunction

   task automatic check_field(input string fname, input int want, input int got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      end
   endtask

   always @(posedge clock) begin : monitor_step
      snoop_result_type want;
      snoop_result_type got;
      if (reset) begin
         clear_monitor();
      end else begin
         // results first: an item taken at this edge cannot be answered at the same edge
         if (rsp_valid && !rsp_stall) begin
            got.st_valid = rsp_stored_valid;
            got.st_index = rsp_stored_index;
            got.st_value = rsp_stored_value;
            got.address  = rsp_target_addr;
            got.idle     = rsp_bus_idle;
            got.writing  = rsp_master_writing;
            got.rd_value = rsp_read_value;
            if (pending_results.size() == 0) begin
               mismatch_count++;
               $display("%0t ns: unexpected item on result channel, expected none, actual %h",
                        $time, got);
            end else begin
               want = pending_results.pop_front();
               check_field("stored_valid", want.st_valid, got.st_valid);
               check_field("stored_index", want.st_index, got.st_index);
               check_field("stored_value", want.st_value, got.st_value);
               check_field("target_addr", want.address, got.address);
               check_field("bus_idle", want.idle, got.idle);
               check_field("master_writing", want.writing, got.writing);
               check_field("read_value", want.rd_value, got.rd_value);
            end
         end
         if (req_valid && !req_stall)
            pending_results.push_back(predict_bus_event(req_action, req_sda_level,
                                                        req_scl_level, req_read_index));
      end
      mismatches <= mismatch_count;
      awaiting   <= pending_results.size();
   end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Top of the I2C bus snoop capture testbench: clock, reset, bus event stimulus, result
// stall pattern, watchdog and verdict. Depends on ibs_pkg, the block and ibs_snoop_checker.
module testbench
   import ibs_pkg::*;
();

   // the one event code the block does not use; it must change nothing
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS   = 1750;
   localparam int HOLD_CYCLES    = 300;   // long result hold-off, fills the block up
   localparam int WATCHDOG_LIMIT = 3000;  // cycles with no item moving on either channel
   localparam int SETTLE_CYCLES  = 10;    // leave a margin at the end

   logic       clock;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_stall;
   logic [1:0] req_action     = ACT_SCL_RISE;
   logic       req_sda_level  = 1'b1;
   logic       req_scl_level  = 1'b1;
   logic [7:0] req_read_index = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall      = 1'b0;
   logic       rsp_stored_valid;
   logic [7:0] rsp_stored_index;
   logic [7:0] rsp_stored_value;
   logic [6:0] rsp_target_addr;
   logic       rsp_bus_idle;
   logic       rsp_master_writing;
   logic [7:0] rsp_read_value;

   int         mismatches;
   int         awaiting;

   int         items_sent = 0;
   int         burst_left = 8;
   int         hold_req   = 0;       // bumped by the stimulus to ask for one long hold-off
   logic [7:0] last_ptr   = 8'd0;    // last register pointer set, so reads hit fresh data

   i2c_bus_snoop_register_capture dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_sda_level      (req_sda_level),
      .req_scl_level      (req_scl_level),
      .req_read_index     (req_read_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_stored_valid   (rsp_stored_valid),
      .rsp_stored_index   (rsp_stored_index),
      .rsp_stored_value   (rsp_stored_value),
      .rsp_target_addr    (rsp_target_addr),
      .rsp_bus_idle       (rsp_bus_idle),
      .rsp_master_writing (rsp_master_writing),
      .rsp_read_value     (rsp_read_value)
   );

   ibs_snoop_checker snoop_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_sda_level      (req_sda_level),
      .req_scl_level      (req_scl_level),
      .req_read_index     (req_read_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_stored_valid   (rsp_stored_valid),
      .rsp_stored_index   (rsp_stored_index),
      .rsp_stored_value   (rsp_stored_value),
      .rsp_target_addr    (rsp_target_addr),
      .rsp_bus_idle       (rsp_bus_idle),
      .rsp_master_writing (rsp_master_writing),
      .rsp_read_value     (rsp_read_value),
      .mismatches         (mismatches),
      .awaiting           (awaiting)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // One item on the event channel. Valid and payload are set at the edge, then held
   // until the block takes the item. At the end of a burst valid drops for a short gap;
   // otherwise the next call keeps valid high with one assignment in that step.
   task automatic put_item(input logic [1:0] act, input logic sda, input logic scl,
                           input logic [7:0] idx);
      req_valid      <= 1'b1;
      req_action     <= act;
      req_sda_level  <= sda;
      req_scl_level  <= scl;
      req_read_index <= idx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         // now and then a long burst, so there are stretches with no sender gaps
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
      end
   endtask

   // Eight data bits MSB first, then the acknowledge bit (low = ACK). SCL level is
   // don't-care on a rising edge and read_index on anything but a read, so both are
   // randomised. Occasionally SDA moves while SCL is low first, as on a real bus.
   task automatic put_byte(input logic [7:0] b, input logic ack_level);
      for (int i = 7; i >= 0; i--) begin
         if ($urandom_range(0, 9) == 0)
            put_item(ACT_SDA_CHANGE, b[i], 1'b0, 8'($urandom));
         put_item(ACT_SCL_RISE, b[i], 1'($urandom), 8'($urandom));
      end
      put_item(ACT_SCL_RISE, ack_level, 1'($urandom), 8'($urandom));
   endtask

   // One bus transfer: START, address byte, pointer byte on writes, data bytes,
   // then mostly STOP. A few are broken off mid-byte, carry a repeated START, or
   // leave the bus busy so the next START is swallowed.
   task automatic bus_transfer();
      logic [6:0] addr;
      logic       rd;
      logic       ack;
      logic [7:0] ptr;
      int         n;
      int         ending;
      addr = 7'($urandom);
      rd   = ($urandom_range(0, 3) == 0);
      put_item(ACT_SDA_CHANGE, 1'b0, 1'b1, 8'($urandom));
      put_byte({addr, rd}, $urandom_range(0, 9) == 0);
      if (!rd) begin
         // bias pointers towards the top so the store wraps often
         ptr = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(236, 255)) : 8'($urandom);
         ack = ($urandom_range(0, 7) == 0);
         put_byte(ptr, ack);
         if (!ack) last_ptr = ptr;
      end
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 5);
      repeat (n) put_byte(8'($urandom), $urandom_range(0, 4) == 0);
      ending = $urandom_range(0, 9);
      if (ending == 0) begin
         repeat ($urandom_range(1, 7))
            put_item(ACT_SCL_RISE, 1'($urandom), 1'($urandom), 8'($urandom));
      end else if (ending == 1) begin
         // repeated START while busy: ignored, the byte after it carries on as data
         put_item(ACT_SDA_CHANGE, 1'b0, 1'b1, 8'($urandom));
         put_byte(8'($urandom), 1'($urandom));
      end
      if (ending != 2)
         put_item(ACT_SDA_CHANGE, 1'b1, 1'b1, 8'($urandom));
      repeat ($urandom_range(0, 3))
         put_item(ACT_READ, 1'($urandom), 1'($urandom), last_ptr + 8'($urandom_range(0, 7)));
   endtask

   // stimulus and verdict
   initial begin
      int  target;
      int  sel;
      bit  paused;
      paused = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // -- directed part --
      // store reads as zero after reset, at both ends
      put_item(ACT_READ, 1'b0, 1'b0, 8'd0);
      put_item(ACT_READ, 1'b1, 1'b1, 8'd255);
      // unused code changes nothing
      put_item(ACT_UNUSED, 1'b1, 1'b1, 8'hFF);
      // SCL edge while idle, then SDA moving under SCL low: both ignored
      put_item(ACT_SCL_RISE, 1'b1, 1'b0, 8'h00);
      put_item(ACT_SDA_CHANGE, 1'b0, 1'b0, 8'h55);
      // START, all-ones address with read direction, NACKed: address keeps its old value
      put_item(ACT_SDA_CHANGE, 1'b0, 1'b1, 8'hAA);
      put_byte(8'hFF, 1'b1);
      // first byte of a read transfer is stored at pointer zero
      put_byte(8'hA5, 1'b0);
      // repeated START while busy is ignored; STOP frees the bus
      put_item(ACT_SDA_CHANGE, 1'b0, 1'b1, 8'h0F);
      put_item(ACT_SDA_CHANGE, 1'b1, 1'b1, 8'hF0);
      put_item(ACT_READ, 1'b0, 1'b1, 8'd0);

      // -- random part --
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         // one long result hold-off while items keep coming, so the block backs up
         if (hold_req == 0 && items_sent > 500)
            hold_req <= 1;
         // one pause with the sender quiet until every result is back
         if (!paused && items_sent > 1100) begin
            paused = 1'b1;
            req_valid <= 1'b0;
            do @(posedge clock); while (awaiting != 0);
         end
         sel = $urandom_range(0, 19);
         if (sel < 15) begin
            bus_transfer();
         end else if (sel < 18) begin
            repeat ($urandom_range(1, 4))
               put_item(2'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
         end else begin
            repeat ($urandom_range(1, 4))
               put_item(ACT_READ, 1'($urandom), 1'($urandom), 8'($urandom));
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (awaiting != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && awaiting == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Result stall pattern: spans of free flow, light, heavy and periodic stalling,
   // and the long hold-off when the stimulus asks for it.
   initial begin
      int mode;
      int period;
      int holds_served;
      holds_served = 0;
      forever begin
         mode   = $urandom_range(0, 3);
         period = $urandom_range(2, 5);
         repeat ($urandom_range(20, 200)) begin
            @(posedge clock);
            if (hold_req != holds_served) begin
               holds_served = hold_req;
               rsp_stall <= 1'b1;
               repeat (HOLD_CYCLES - 1) @(posedge clock);
            end else begin
               case (mode)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= ($urandom_range(0, 3) == 0);
                  2: rsp_stall <= ($urandom_range(0, 9) < 7);
                  default: rsp_stall <= ($urandom_range(0, period - 1) == 0);
               endcase
            end
         end
      end
   end

   // watchdog: ends the run if nothing moves on either channel for too long
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb: failure");
      $finish;
   end

endmodule
